// ===== rtl/ppc_pkg.sv =====
`default_nettype none
package ppc_pkg;

  localparam int unsigned MaxPolygonVertices = 64;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned InCntW = 7;
  localparam int unsigned OutCntW = 8;
  localparam int unsigned ScaleW = 18;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [51:0] dist_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [31:0] offset;
    logic [15:0]        margin;
  } cfg_t;

  // one edge a -> b, closing marks the edge back to the first vertex
  typedef struct packed {
    coord_t [2:0] a;
    dist_t        da;
    logic         ia;
    coord_t [2:0] b;
    dist_t        db;
    logic         ib;
    logic         closing;
    logic         in_ge3;
  } job_t;

  typedef enum logic [2:0] {
    RegNormalX = 3'd0,
    RegNormalY = 3'd1,
    RegNormalZ = 3'd2,
    RegOffset  = 3'd3,
    RegMargin  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_PUSH_E,
    F_PUSH_C
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_EMIT_A,
    B_TEST,
    B_SETUP,
    B_QINT,
    B_FRAC,
    B_ROUND,
    B_SAT,
    B_MUL,
    B_ADD,
    B_EMIT_P,
    B_EMIT_SUM
  } back_state_e;

endpackage
`default_nettype wire

// ===== rtl/ppc_queue.sv =====
`default_nettype none
module ppc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ppc_pkg::job_t job_i,
  input  wire logic          pop_i,
  output ppc_pkg::job_t      job_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned Depth = ppc_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(Depth);

  ppc_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ppc_front.sv =====
`default_nettype none
module ppc_front #(
  parameter int unsigned MAX_POLYGON_VERTICES = ppc_pkg::MaxPolygonVertices
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ppc_pkg::cfg_t         cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ppc_pkg::coord_t [2:0] in_point_i,
  input  wire logic                  in_last_i,
  output logic                       push_o,
  output ppc_pkg::job_t              job_o,
  input  wire logic                  full_i
);

  localparam int unsigned InCap = (MAX_POLYGON_VERTICES < 127) ? MAX_POLYGON_VERTICES : 127;
  localparam logic [ppc_pkg::InCntW-1:0] InCapV = ppc_pkg::InCntW'(InCap);

  ppc_pkg::front_state_e state_q, state_d;

  ppc_pkg::coord_t [2:0] cur_q, prev_q, first_q;
  logic                  last_q;
  logic signed [47:0]    prod_q [3];
  ppc_pkg::dist_t        d_q, prev_d_q, first_d_q;
  logic                  inside_q, prev_in_q;
  logic [ppc_pkg::InCntW-1:0] in_cnt_q;

  logic signed [32:0]    thr33;
  ppc_pkg::dist_t        thr;
  ppc_pkg::dist_t        d_sum;
  logic                  leave_e;

  // (offset - margin) scaled to 14 fraction bits
  assign thr33 = $signed({cfg_i.offset[31], cfg_i.offset}) - $signed({17'b0, cfg_i.margin});
  assign thr   = $signed({{5{thr33[32]}}, thr33, 14'b0});
  assign d_sum = $signed({{4{prod_q[0][47]}}, prod_q[0]})
               + $signed({{4{prod_q[1][47]}}, prod_q[1]})
               + $signed({{4{prod_q[2][47]}}, prod_q[2]});

  assign leave_e = (state_q == ppc_pkg::F_PUSH_E) && ((in_cnt_q == '0) || !full_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ppc_pkg::F_IDLE:   if (in_valid_i) state_d = ppc_pkg::F_MUL;
      ppc_pkg::F_MUL:    state_d = ppc_pkg::F_SUM;
      ppc_pkg::F_SUM:    state_d = ppc_pkg::F_PUSH_E;
      ppc_pkg::F_PUSH_E: begin
        if (leave_e) state_d = last_q ? ppc_pkg::F_PUSH_C : ppc_pkg::F_IDLE;
      end
      ppc_pkg::F_PUSH_C: if (!full_i) state_d = ppc_pkg::F_IDLE;
      default:           state_d = ppc_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ppc_pkg::F_IDLE);
    push_o     = 1'b0;
    job_o.closing = 1'b0;
    job_o.in_ge3  = 1'b0;
    job_o.a  = prev_q;
    job_o.da = prev_d_q;
    job_o.ia = prev_in_q;
    job_o.b  = cur_q;
    job_o.db = d_q;
    job_o.ib = inside_q;
    case (state_q)
      ppc_pkg::F_PUSH_E: push_o = (in_cnt_q != '0) && !full_i;
      ppc_pkg::F_PUSH_C: begin
        push_o        = !full_i;
        job_o.closing = 1'b1;
        job_o.in_ge3  = (in_cnt_q >= ppc_pkg::InCntW'(3));
        job_o.b       = first_q;
        job_o.db      = first_d_q;
        job_o.ib      = (first_d_q >= thr);
      end
      default: push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cur_q  <= in_point_i;
      last_q <= in_last_i;
    end
    if (state_q == ppc_pkg::F_MUL) begin
      prod_q[0] <= $signed(cur_q[0]) * cfg_i.nx;
      prod_q[1] <= $signed(cur_q[1]) * cfg_i.ny;
      prod_q[2] <= $signed(cur_q[2]) * cfg_i.nz;
    end
    if (state_q == ppc_pkg::F_SUM) begin
      d_q      <= d_sum;
      inside_q <= (d_sum >= thr);
    end
    if (leave_e) begin
      prev_q    <= cur_q;
      prev_d_q  <= d_q;
      prev_in_q <= inside_q;
      if (in_cnt_q == '0) begin
        first_q   <= cur_q;
        first_d_q <= d_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ppc_pkg::F_IDLE;
      in_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (leave_e && (in_cnt_q < InCapV)) begin
        in_cnt_q <= in_cnt_q + 1'b1;
      end else if ((state_q == ppc_pkg::F_PUSH_C) && !full_i) begin
        in_cnt_q <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ppc_back.sv =====
`default_nettype none
module ppc_back #(
  parameter int unsigned MAX_POLYGON_VERTICES = ppc_pkg::MaxPolygonVertices
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ppc_pkg::cfg_t cfg_i,
  input  wire ppc_pkg::job_t job_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               out_kind_o,
  output ppc_pkg::coord_t [2:0] out_point_o,
  output logic [ppc_pkg::OutCntW-1:0] out_count_o,
  output logic               out_kept_o
);

  localparam int unsigned OutCap =
    (2*MAX_POLYGON_VERTICES < 255) ? 2*MAX_POLYGON_VERTICES : 255;
  localparam logic [ppc_pkg::OutCntW-1:0] OutCapV = ppc_pkg::OutCntW'(OutCap);
  localparam int unsigned SW = ppc_pkg::ScaleW;

  ppc_pkg::back_state_e state_q, state_d;
  ppc_pkg::job_t        job_q;

  logic [52:0]          un_q, ud_q, r_q;
  logic                 neg_q;
  logic [SW-1:0]        q_q;
  logic [3:0]           frac_q;
  logic signed [SW-1:0] s_q;
  logic [1:0]           idx_q;
  logic signed [50:0]   prod_q;
  ppc_pkg::coord_t [2:0] pt_q;
  logic [ppc_pkg::OutCntW-1:0] ocnt_q;

  logic                 out_valid_q, out_kind_q, out_kept_q;
  ppc_pkg::coord_t [2:0] out_pt_q;
  logic [ppc_pkg::OutCntW-1:0] out_cnt_q;

  logic                 slot_free;
  logic                 load_a, load_p, load_s;
  logic                 crossing, big_ratio, q0_ge;
  logic signed [52:0]   num, den;
  logic [53:0]          r2;
  logic                 r2_ge;
  logic signed [32:0]   diff;
  logic [50:0]          mag;
  logic [51:0]          mag_r;
  logic signed [37:0]   sum38;
  ppc_pkg::coord_t      pt_sat;
  ppc_pkg::coord_t      a_sel, b_sel;

  assign slot_free = !out_valid_q || out_ready_i;
  assign crossing  = (job_q.ia != job_q.ib) && (job_q.db != job_q.da);
  assign big_ratio = ({1'b0, un_q} >= {ud_q, 1'b0});
  assign q0_ge     = (un_q >= ud_q);

  assign num = $signed({{7{cfg_i.offset[31]}}, cfg_i.offset, 14'b0})
             - $signed({job_q.da[51], job_q.da});
  assign den = $signed({job_q.db[51], job_q.db}) - $signed({job_q.da[51], job_q.da});

  assign r2    = {r_q, 1'b0};
  assign r2_ge = (r2 >= {1'b0, ud_q});

  assign a_sel = job_q.a[idx_q];
  assign b_sel = job_q.b[idx_q];
  assign diff  = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});

  // round half away from zero at 2^-16, then saturate
  assign mag   = prod_q[50] ? 51'(-prod_q) : 51'(prod_q);
  assign mag_r = {1'b0, mag} + 52'd32768;
  assign sum38 = prod_q[50]
               ? $signed({{6{a_sel[31]}}, a_sel}) - $signed({2'b0, mag_r[51:16]})
               : $signed({{6{a_sel[31]}}, a_sel}) + $signed({2'b0, mag_r[51:16]});
  assign pt_sat = (sum38 > 38'sh007fffffff) ? 32'sh7fffffff
                : (sum38 < -38'sh0080000000) ? 32'sh80000000
                : sum38[31:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ppc_pkg::B_IDLE:     if (!empty_i) state_d = ppc_pkg::B_EMIT_A;
      ppc_pkg::B_EMIT_A:   if (!job_q.ia || slot_free) state_d = ppc_pkg::B_TEST;
      ppc_pkg::B_TEST: begin
        if (crossing)           state_d = ppc_pkg::B_SETUP;
        else if (job_q.closing) state_d = ppc_pkg::B_EMIT_SUM;
        else                    state_d = ppc_pkg::B_IDLE;
      end
      ppc_pkg::B_SETUP:    state_d = ppc_pkg::B_QINT;
      ppc_pkg::B_QINT:     state_d = big_ratio ? ppc_pkg::B_SAT : ppc_pkg::B_FRAC;
      ppc_pkg::B_FRAC:     if (frac_q == 4'd15) state_d = ppc_pkg::B_ROUND;
      ppc_pkg::B_ROUND:    state_d = ppc_pkg::B_SAT;
      ppc_pkg::B_SAT:      state_d = ppc_pkg::B_MUL;
      ppc_pkg::B_MUL:      state_d = ppc_pkg::B_ADD;
      ppc_pkg::B_ADD:      state_d = (idx_q == 2'd2) ? ppc_pkg::B_EMIT_P : ppc_pkg::B_MUL;
      ppc_pkg::B_EMIT_P: begin
        if (slot_free) state_d = job_q.closing ? ppc_pkg::B_EMIT_SUM : ppc_pkg::B_IDLE;
      end
      ppc_pkg::B_EMIT_SUM: if (slot_free) state_d = ppc_pkg::B_IDLE;
      default:             state_d = ppc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    load_a = 1'b0;
    load_p = 1'b0;
    load_s = 1'b0;
    case (state_q)
      ppc_pkg::B_IDLE:     pop_o  = !empty_i;
      ppc_pkg::B_EMIT_A:   load_a = job_q.ia && slot_free;
      ppc_pkg::B_EMIT_P:   load_p = slot_free;
      ppc_pkg::B_EMIT_SUM: load_s = slot_free;
      default:             pop_o  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    case (state_q)
      ppc_pkg::B_SETUP: begin
        un_q  <= num[52] ? 53'(-num) : 53'(num);
        ud_q  <= den[52] ? 53'(-den) : 53'(den);
        neg_q <= num[52] ^ den[52];
      end
      ppc_pkg::B_QINT: begin
        frac_q <= '0;
        if (big_ratio) begin
          q_q <= SW'(1) << 17;
        end else begin
          q_q <= SW'(q0_ge);
          r_q <= q0_ge ? un_q - ud_q : un_q;
        end
      end
      ppc_pkg::B_FRAC: begin
        r_q    <= r2_ge ? 53'(r2 - {1'b0, ud_q}) : r2[52:0];
        q_q    <= {q_q[SW-2:0], r2_ge};
        frac_q <= frac_q + 1'b1;
      end
      ppc_pkg::B_ROUND: begin
        if (r2_ge) q_q <= q_q + 1'b1;
      end
      ppc_pkg::B_SAT: begin
        idx_q <= '0;
        if (neg_q)                      s_q <= $signed(-q_q);
        else if (q_q > SW'(131071))     s_q <= SW'(131071);
        else                            s_q <= $signed(q_q);
      end
      ppc_pkg::B_MUL: prod_q <= diff * s_q;
      ppc_pkg::B_ADD: begin
        pt_q[idx_q] <= pt_sat;
        idx_q       <= idx_q + 1'b1;
      end
      default: ;
    endcase
    if (load_a || load_p || load_s) begin
      out_kind_q <= load_s;
      out_pt_q   <= load_a ? job_q.a : (load_p ? pt_q : '0);
      out_cnt_q  <= load_s ? ocnt_q : '0;
      out_kept_q <= load_s && job_q.in_ge3 && (ocnt_q >= ppc_pkg::OutCntW'(3));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppc_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      ocnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_a || load_p || load_s) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_s) begin
        ocnt_q <= '0;
      end else if ((load_a || load_p) && (ocnt_q < OutCapV)) begin
        ocnt_q <= ocnt_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_point_o = out_pt_q;
  assign out_count_o = out_cnt_q;
  assign out_kept_o  = out_kept_q;

endmodule
`default_nettype wire

// ===== rtl/polygon_plane_clipper.sv =====
// front: per vertex capture, products, dot sum, queue push (held while the queue is full), and a
// closing-edge push on the last vertex; back: per edge pop, start vertex, test, a kept start vertex
// is loaded for output in the second; a crossing edge adds the bit-serial scale divider (17 steps),
// rounding unless the scale saturates, and the shared multiplier; the summary item ends a closing edge;
// the front takes the next vertex while the back still works on queued edges; async active-low reset
`default_nettype none
module polygon_plane_clipper #(
  parameter int unsigned MAX_POLYGON_VERTICES = ppc_pkg::MaxPolygonVertices
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [95:0]   s_axis_tdata_i,   // point_x, point_y, point_z
  input  wire logic          s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [111:0]       m_axis_tdata_o,   // out_x, out_y, out_z, vertex_count, polygon_kept, pad
  output logic               m_axis_tuser_o,   // item_kind
  input  wire logic          psel_i,
  input  wire logic          penable_i,
  input  wire logic          pwrite_i,
  input  wire logic [4:0]    paddr_i,
  input  wire logic [31:0]   pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  ppc_pkg::cfg_t cfg_q;
  ppc_pkg::reg_idx_e ridx;
  logic cfg_wr;

  ppc_pkg::coord_t [2:0] in_pt;
  logic push, pop, full, empty;
  ppc_pkg::job_t job_in, job_out;

  logic out_kind, out_kept;
  ppc_pkg::coord_t [2:0] out_pt;
  logic [ppc_pkg::OutCntW-1:0] out_cnt;

  assign pready_o = 1'b1;
  assign ridx     = ppc_pkg::reg_idx_e'(paddr_i[4:2]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nx     <= '0;
      cfg_q.ny     <= '0;
      cfg_q.nz     <= 16'sd16384;
      cfg_q.offset <= '0;
      cfg_q.margin <= '0;
    end else if (cfg_wr) begin
      case (ridx)
        ppc_pkg::RegNormalX: cfg_q.nx     <= pwdata_i[15:0];
        ppc_pkg::RegNormalY: cfg_q.ny     <= pwdata_i[15:0];
        ppc_pkg::RegNormalZ: cfg_q.nz     <= pwdata_i[15:0];
        ppc_pkg::RegOffset:  cfg_q.offset <= pwdata_i;
        ppc_pkg::RegMargin:  cfg_q.margin <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      ppc_pkg::RegNormalX: prdata_o = {16'b0, cfg_q.nx};
      ppc_pkg::RegNormalY: prdata_o = {16'b0, cfg_q.ny};
      ppc_pkg::RegNormalZ: prdata_o = {16'b0, cfg_q.nz};
      ppc_pkg::RegOffset:  prdata_o = cfg_q.offset;
      ppc_pkg::RegMargin:  prdata_o = {16'b0, cfg_q.margin};
      default:             prdata_o = '0;
    endcase
  end

  assign in_pt[0] = s_axis_tdata_i[31:0];
  assign in_pt[1] = s_axis_tdata_i[63:32];
  assign in_pt[2] = s_axis_tdata_i[95:64];

  ppc_front #(.MAX_POLYGON_VERTICES(MAX_POLYGON_VERTICES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_point_i (in_pt),
    .in_last_i  (s_axis_tlast_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  ppc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  ppc_back #(.MAX_POLYGON_VERTICES(MAX_POLYGON_VERTICES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (out_kind),
    .out_point_o (out_pt),
    .out_count_o (out_cnt),
    .out_kept_o  (out_kept)
  );

  assign m_axis_tuser_o = out_kind;
  assign m_axis_tdata_o = {7'b0, out_kept, out_cnt, out_pt[2], out_pt[1], out_pt[0]};

endmodule
`default_nettype wire
